// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms, clocked and held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RLESD_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("rlesd: same-cycle property violated");

// next-cycle implication
`define RLESD_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("rlesd: next-cycle property violated");

`endif

// File: rtl/core/rlesd_pkg.sv
// ----------------------------------------------------------------------------
// rlesd_pkg
// types, register codes and color tables of the scan-line run decoder
// ----------------------------------------------------------------------------
package rlesd_pkg;

    localparam int DEF_MAX_WIDTH = 8192;
    localparam int ROW_WIDTH_MAX = 16383;
    localparam int COUNT_W       = 7;
    localparam int PIX_W         = 13;

    typedef enum logic [2:0] {
        REG_ROW_WIDTH     = 3'd0,
        REG_BYTES_PER_CH  = 3'd1,
        REG_COLOR_MODE    = 3'd2,
        REG_CHANNELS_USED = 3'd3,
        REG_RLE_MODE      = 3'd4
    } reg_index_t;

    localparam logic [1:0] CM_DITHER  = 2'd1;
    localparam logic [1:0] CH_RED     = 2'd0;
    localparam logic [1:0] CH_GREEN   = 2'd1;
    localparam logic [1:0] CH_BLUE    = 2'd2;
    localparam logic [2:0] GREY_LIMIT = 3'd2;
    localparam logic [2:0] GREY_ALPHA = 3'd2;

    localparam logic [3:0] MASK_RED   = 4'b0001;
    localparam logic [3:0] MASK_GREEN = 4'b0010;
    localparam logic [3:0] MASK_BLUE  = 4'b0100;
    localparam logic [3:0] MASK_ALPHA = 4'b1000;
    localparam logic [3:0] MASK_RGB   = 4'b0111;

    // 3-bit and 2-bit fields scaled to full byte range
    localparam logic [7:0] DITH3_LUT [8] = '{8'd0, 8'd36, 8'd73, 8'd109,
                                             8'd146, 8'd182, 8'd219, 8'd255};
    localparam logic [7:0] DITH2_LUT [4] = '{8'd0, 8'd85, 8'd170, 8'd255};

    typedef enum logic [2:0] {
        PH_CODE = 3'b001,
        PH_LIT  = 3'b010,
        PH_REP  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [13:0] row_width;
        logic [1:0]  bytes_per_channel;
        logic [1:0]  color_mode;
        logic [2:0]  channels_used;
        logic        rle_mode;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] channel;
        logic       segment_last;
    } in_item_t;

    typedef struct packed {
        logic [3:0] write_mask;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } color_t;

    typedef struct packed {
        logic [12:0] pixel_start;
        logic [6:0]  run_length;
        color_t      color;
        logic        row_done;
        logic        row_status;
    } out_beat_t;

    typedef struct packed {
        logic      has_result;
        out_beat_t res;
    } step_t;

endpackage

// File: rtl/core/rlesd_in_if.sv
// ----------------------------------------------------------------------------
// rlesd_in_if
// byte stream channel, one segment byte per beat
// ----------------------------------------------------------------------------
interface rlesd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [1:0] channel;
    logic       segment_last;

    modport source (output valid, data_byte, channel, segment_last, input ready);
    modport sink (input valid, data_byte, channel, segment_last, output ready);
endinterface

// File: rtl/core/rlesd_out_if.sv
// ----------------------------------------------------------------------------
// rlesd_out_if
// run write channel, one masked run or row status per beat
// ----------------------------------------------------------------------------
interface rlesd_out_if;
    logic        valid;
    logic        ready;
    logic [12:0] pixel_start;
    logic [6:0]  run_length;
    logic [3:0]  write_mask;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        row_done;
    logic        row_status;

    modport source (output valid, pixel_start, run_length, write_mask, red, green, blue,
                    alpha, row_done, row_status, input ready);
    modport sink (input valid, pixel_start, run_length, write_mask, red, green, blue,
                  alpha, row_done, row_status, output ready);
endinterface

// File: rtl/core/rlesd_cfg_if.sv
// ----------------------------------------------------------------------------
// rlesd_cfg_if
// register write channel, index and data per beat
// ----------------------------------------------------------------------------
interface rlesd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [13:0] wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink (input valid, index, wdata, output ready);
endinterface

// File: rtl/core/rlesd_cfg_regs.sv
// ----------------------------------------------------------------------------
// rlesd_cfg_regs
// configuration register file, written one register per beat
// ----------------------------------------------------------------------------
module rlesd_cfg_regs
    import rlesd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rlesd_cfg_if.sink   cfg,
    output cfg_t        cfg_q
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (reg_index_t'(cfg.index))
                REG_ROW_WIDTH:     cfg_next.row_width         = cfg.wdata;
                REG_BYTES_PER_CH:  cfg_next.bytes_per_channel = cfg.wdata[1:0];
                REG_COLOR_MODE:    cfg_next.color_mode        = cfg.wdata[1:0];
                REG_CHANNELS_USED: cfg_next.channels_used     = cfg.wdata[2:0];
                REG_RLE_MODE:      cfg_next.rle_mode          = cfg.wdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_width         <= 14'd1;
            cfg_reg.bytes_per_channel <= 2'd1;
            cfg_reg.color_mode        <= 2'd0;
            cfg_reg.channels_used     <= 3'd1;
            cfg_reg.rle_mode          <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/rlesd_color_map.sv
// ----------------------------------------------------------------------------
// rlesd_color_map
// maps one channel value to a masked rgba write
// ----------------------------------------------------------------------------
module rlesd_color_map
    import rlesd_pkg::*;
(
    input  cfg_t        cfg,
    input  logic [1:0]  channel,
    input  logic [7:0]  value,
    output color_t      color
);

    always_comb
    begin
        color = '0;
        priority if (cfg.color_mode == CM_DITHER)
        begin
            color.write_mask = MASK_RGB;
            color.red        = DITH3_LUT[value[2:0]];
            color.green      = DITH3_LUT[value[5:3]];
            color.blue       = DITH2_LUT[value[7:6]];
        end
        else if (cfg.channels_used <= GREY_LIMIT && channel == CH_RED)
        begin
            color.write_mask = MASK_RGB;
            color.red        = value;
            color.green      = value;
            color.blue       = value;
        end
        else if (cfg.channels_used == GREY_ALPHA)
        begin
            color.write_mask = MASK_ALPHA;
            color.alpha      = value;
        end
        else
        begin
            unique case (channel)
                CH_RED:
                begin
                    color.write_mask = MASK_RED;
                    color.red        = value;
                end
                CH_GREEN:
                begin
                    color.write_mask = MASK_GREEN;
                    color.green      = value;
                end
                CH_BLUE:
                begin
                    color.write_mask = MASK_BLUE;
                    color.blue       = value;
                end
                default:
                begin
                    color.write_mask = MASK_ALPHA;
                    color.alpha      = value;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/rlesd_parser.sv
// ----------------------------------------------------------------------------
// rlesd_parser
// token parse state, run bookkeeping and row status for one byte per cycle while commit is high
// ----------------------------------------------------------------------------
module rlesd_parser
    import rlesd_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  in_item_t  item,
    input  logic      commit,
    output step_t     step
);

    localparam int CLAMP_W = (MAX_WIDTH < ROW_WIDTH_MAX) ? MAX_WIDTH : ROW_WIDTH_MAX;
    localparam int POS_W   = $clog2(CLAMP_W + 1);
    localparam int CMP_W   = (POS_W > COUNT_W) ? POS_W : COUNT_W;
    localparam int EXT_W   = (POS_W > PIX_W) ? POS_W : PIX_W;

    logic [POS_W-1:0] pos_reg, pos_next;
    phase_t           phase_reg, phase_next;
    logic             bit_reg, bit_next;
    logic [6:0]       left_reg, left_next;
    logic [7:0]       held_reg, held_next;
    logic             settled_reg, settled_next;

    logic             two;
    logic             complete;
    logic             wr;
    logic             settle_now;
    logic             bad;
    logic [6:0]       wr_len;
    logic [6:0]       count;
    logic [7:0]       value;
    logic [POS_W-1:0] width_lim;
    logic [POS_W:0]   rem;
    logic [EXT_W-1:0] pos_ext;
    color_t           color;

    rlesd_color_map u_color_map (
        .cfg     (cfg),
        .channel (item.channel),
        .value   (value),
        .color   (color)
    );

    assign two       = (cfg.bytes_per_channel >= 2'd2);
    assign width_lim = (cfg.row_width > 14'(CLAMP_W)) ? POS_W'(CLAMP_W)
                                                       : POS_W'(cfg.row_width);
    assign rem       = {1'b0, width_lim} - {1'b0, pos_reg};
    assign count     = item.data_byte[6:0];
    assign value     = bit_reg ? held_reg : item.data_byte;
    assign pos_ext   = EXT_W'(pos_reg);

    always_comb
    begin
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        bit_next     = bit_reg;
        left_next    = left_reg;
        held_next    = held_reg;
        settled_next = settled_reg;
        complete     = 1'b0;
        wr           = 1'b0;
        wr_len       = '0;
        settle_now   = 1'b0;
        bad          = 1'b0;

        if (!settled_reg)
        begin
            // token assembly
            if (!bit_reg)
            begin
                held_next = item.data_byte;
                if (two)
                    bit_next = 1'b1;
                else
                    complete = 1'b1;
            end
            else
            begin
                bit_next = 1'b0;
                complete = 1'b1;
            end

            if (complete)
            begin
                if (!cfg.rle_mode)
                begin
                    if (pos_reg >= width_lim)
                    begin
                        settle_now = 1'b1;
                        bad        = 1'b1;
                    end
                    else
                    begin
                        wr       = 1'b1;
                        wr_len   = 7'd1;
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
                else
                begin
                    unique case (phase_reg)
                        PH_LIT:
                        begin
                            wr        = 1'b1;
                            wr_len    = 7'd1;
                            pos_next  = pos_reg + POS_W'(1);
                            left_next = left_reg - 7'd1;
                            if (left_next == 7'd0)
                                phase_next = PH_CODE;
                        end
                        PH_REP:
                        begin
                            wr         = 1'b1;
                            wr_len     = left_reg;
                            pos_next   = pos_reg + POS_W'(left_reg);
                            left_next  = '0;
                            phase_next = PH_CODE;
                        end
                        default:
                        begin
                            if (count == 7'd0)
                            begin
                                settle_now = 1'b1;
                                bad        = (pos_reg != width_lim);
                            end
                            else if (!rem[POS_W] &&
                                     (CMP_W'(count) > CMP_W'(rem[POS_W-1:0])))
                            begin
                                settle_now = 1'b1;
                                bad        = 1'b1;
                            end
                            else
                            begin
                                left_next  = count;
                                phase_next = item.data_byte[7] ? PH_LIT : PH_REP;
                            end
                        end
                    endcase
                end
            end

            // end of segment settles the row if nothing did
            if (item.segment_last && !settle_now)
            begin
                settle_now = 1'b1;
                if (cfg.rle_mode)
                    bad = (phase_next != PH_CODE) || (pos_next != width_lim);
                else
                    bad = bit_next || (pos_next != width_lim);
            end
            settled_next = settle_now;
        end

        if (item.segment_last)
        begin
            pos_next     = '0;
            phase_next   = PH_CODE;
            bit_next     = 1'b0;
            left_next    = '0;
            held_next    = '0;
            settled_next = 1'b0;
        end
    end

    always_comb
    begin
        step                 = '0;
        step.has_result      = !settled_reg && (wr || settle_now);
        step.res.row_done    = settle_now;
        step.res.row_status  = settle_now && bad;
        if (wr)
        begin
            step.res.pixel_start = pos_ext[PIX_W-1:0];
            step.res.run_length  = wr_len;
            step.res.color       = color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            phase_reg   <= PH_CODE;
            bit_reg     <= 1'b0;
            left_reg    <= '0;
            held_reg    <= '0;
            settled_reg <= 1'b0;
        end
        else if (commit)
        begin
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            bit_reg     <= bit_next;
            left_reg    <= left_next;
            held_reg    <= held_next;
            settled_reg <= settled_next;
        end
    end

endmodule

// File: rtl/core/rle_scanline_channel_decoder_unit.sv
// ----------------------------------------------------------------------------
// rle_scanline_channel_decoder_unit: run-length scan-line channel decoder
// path: byte beat to run beat through the input register, then the result register
// throughput: 1 byte per cycle while no run beat is held back by the run channel
// reset: clears both valid flags and the parse state, registers to defaults
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rle_scanline_channel_decoder_unit
    import rlesd_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    rlesd_cfg_if.sink     cfg,
    rlesd_in_if.sink      byte_stream,
    rlesd_out_if.source   run_stream
);

    cfg_t      cfg_q;
    in_item_t  item_reg;
    logic      item_v_reg, item_v_next;
    out_beat_t res_reg;
    logic      out_v_reg, out_v_next;
    step_t     step;
    logic      take;
    logic      advance;
    logic      load_res;

    rlesd_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    rlesd_parser #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_q),
        .item   (item_reg),
        .commit (advance),
        .step   (step)
    );

    assign take     = byte_stream.valid && byte_stream.ready;
    assign advance  = item_v_reg && (!step.has_result || !out_v_reg || run_stream.ready);
    assign load_res = advance && step.has_result;

    assign byte_stream.ready = !item_v_reg || advance;

    always_comb
    begin
        item_v_next = item_v_reg;
        if (take)
            item_v_next = 1'b1;
        else if (advance)
            item_v_next = 1'b0;

        out_v_next = out_v_reg;
        if (load_res)
            out_v_next = 1'b1;
        else if (run_stream.ready)
            out_v_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            item_v_reg <= item_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.data_byte    <= byte_stream.data_byte;
            item_reg.channel      <= byte_stream.channel;
            item_reg.segment_last <= byte_stream.segment_last;
        end
        if (load_res)
            res_reg <= step.res;
    end

    assign run_stream.valid       = out_v_reg;
    assign run_stream.pixel_start = res_reg.pixel_start;
    assign run_stream.run_length  = res_reg.run_length;
    assign run_stream.write_mask  = res_reg.color.write_mask;
    assign run_stream.red         = res_reg.color.red;
    assign run_stream.green       = res_reg.color.green;
    assign run_stream.blue        = res_reg.color.blue;
    assign run_stream.alpha       = res_reg.color.alpha;
    assign run_stream.row_done    = res_reg.row_done;
    assign run_stream.row_status  = res_reg.row_status;

    `RLESD_ASSERT_IMP(a_write_has_length, clk, rst_n, out_v_reg && !res_reg.row_done, res_reg.run_length != 7'd0)
    `RLESD_ASSERT_IMP(a_status_needs_done, clk, rst_n, out_v_reg && !res_reg.row_done, !res_reg.row_status)
    `RLESD_ASSERT_IMP(a_status_only_blank, clk, rst_n, out_v_reg && res_reg.run_length == 7'd0, res_reg.row_done && res_reg.color.write_mask == 4'd0)
    `RLESD_ASSERT_NEXT(a_result_lands, clk, rst_n, load_res, out_v_reg)

endmodule

// File: test/tb_rle_scanline_channel_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_rle_scanline_channel_decoder_unit
// streams run-length and verbatim scan-line segments through the decoder under
// many register settings, with random gaps and stalls on both channels, and
// compares every run beat field by field with a behavioral decoder model or a typed beat
// ----------------------------------------------------------------------------
module tb_rle_scanline_channel_decoder_unit;
    import rlesd_pkg::*;

    localparam int ITEM_TARGET = 1950;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {
        ROW_SET,
        ROW_PRED,
        ROW_QUIET,
        ROW_TYPED
    } row_kind_t;

    typedef enum {
        SEG_CLEAN,
        SEG_OVER,
        SEG_CUT,
        SEG_NOISE
    } seg_shape_t;

    typedef struct packed {
        row_kind_t   kind;
        reg_index_t  idx;
        logic [13:0] wdata;
        logic [7:0]  data_byte;
        logic [1:0]  channel;
        logic        last;
        out_beat_t   want;
    } dir_row_t;

    localparam out_beat_t NO_BEAT = '0;
    localparam out_beat_t ST_OK   = {13'd0, 7'd0, 4'd0, 32'd0, 1'b1, 1'b0};
    localparam out_beat_t ST_BAD  = {13'd0, 7'd0, 4'd0, 32'd0, 1'b1, 1'b1};

    localparam dir_row_t DIRECTED [31] = '{
        {ROW_QUIET, REG_ROW_WIDTH, 14'd0, 8'h01, CH_RED, 1'b0, NO_BEAT},
        {ROW_TYPED, REG_ROW_WIDTH, 14'd0, 8'hFF, CH_RED, 1'b0,
            out_beat_t'({13'd0, 7'd1, MASK_RGB, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0})},
        {ROW_TYPED, REG_ROW_WIDTH, 14'd0, 8'h00, CH_RED, 1'b1, ST_OK},
        {ROW_TYPED, REG_ROW_WIDTH, 14'd0, 8'h82, CH_RED, 1'b0, ST_BAD},
        {ROW_QUIET, REG_ROW_WIDTH, 14'd0, 8'h55, CH_RED, 1'b1, NO_BEAT},
        {ROW_QUIET, REG_ROW_WIDTH, 14'd0, 8'h81, CH_RED, 1'b0, NO_BEAT},
        {ROW_TYPED, REG_ROW_WIDTH, 14'd0, 8'h00, CH_RED, 1'b1,
            out_beat_t'({13'd0, 7'd1, MASK_RGB, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0})},
        {ROW_TYPED, REG_ROW_WIDTH, 14'd0, 8'h01, CH_RED, 1'b1, ST_BAD},
        {ROW_TYPED, REG_ROW_WIDTH, 14'd0, 8'h00, CH_RED, 1'b1, ST_BAD},
        {ROW_QUIET, REG_ROW_WIDTH, 14'd0, 8'h01, 2'd3, 1'b0, NO_BEAT},
        {ROW_PRED, REG_ROW_WIDTH, 14'd0, 8'hA5, 2'd3, 1'b1, NO_BEAT},
        {ROW_SET, REG_RLE_MODE, 14'd0, 8'h00, CH_RED, 1'b0, NO_BEAT},
        {ROW_PRED, REG_ROW_WIDTH, 14'd0, 8'h12, CH_GREEN, 1'b0, NO_BEAT},
        {ROW_TYPED, REG_ROW_WIDTH, 14'd0, 8'h34, CH_GREEN, 1'b1, ST_BAD},
        {ROW_SET, REG_BYTES_PER_CH, 14'd2, 8'h00, CH_RED, 1'b0, NO_BEAT},
        {ROW_QUIET, REG_ROW_WIDTH, 14'd0, 8'hAB, CH_BLUE, 1'b0, NO_BEAT},
        {ROW_PRED, REG_ROW_WIDTH, 14'd0, 8'hCD, CH_BLUE, 1'b1, NO_BEAT},
        {ROW_TYPED, REG_ROW_WIDTH, 14'd0, 8'h77, CH_BLUE, 1'b1, ST_BAD},
        {ROW_SET, REG_ROW_WIDTH, 14'd16383, 8'h00, CH_RED, 1'b0, NO_BEAT},
        {ROW_SET, REG_COLOR_MODE, 14'd1, 8'h00, CH_RED, 1'b0, NO_BEAT},
        {ROW_SET, REG_RLE_MODE, 14'd1, 8'h00, CH_RED, 1'b0, NO_BEAT},
        {ROW_QUIET, REG_ROW_WIDTH, 14'd0, 8'hFF, CH_GREEN, 1'b0, NO_BEAT},
        {ROW_QUIET, REG_ROW_WIDTH, 14'd0, 8'h7F, CH_GREEN, 1'b0, NO_BEAT},
        {ROW_QUIET, REG_ROW_WIDTH, 14'd0, 8'hFF, CH_GREEN, 1'b0, NO_BEAT},
        {ROW_PRED, REG_ROW_WIDTH, 14'd0, 8'h00, CH_GREEN, 1'b0, NO_BEAT},
        {ROW_TYPED, REG_ROW_WIDTH, 14'd0, 8'h5A, CH_GREEN, 1'b1, ST_BAD},
        {ROW_SET, REG_CHANNELS_USED, 14'd2, 8'h00, CH_RED, 1'b0, NO_BEAT},
        {ROW_SET, REG_COLOR_MODE, 14'd0, 8'h00, CH_RED, 1'b0, NO_BEAT},
        {ROW_SET, REG_BYTES_PER_CH, 14'd1, 8'h00, CH_RED, 1'b0, NO_BEAT},
        {ROW_QUIET, REG_ROW_WIDTH, 14'd0, 8'h81, CH_BLUE, 1'b0, NO_BEAT},
        {ROW_PRED, REG_ROW_WIDTH, 14'd0, 8'h3C, CH_BLUE, 1'b1, NO_BEAT}
    };

    logic clk = 1'b0;
    logic rst_n;

    rlesd_cfg_if cfg_bus ();
    rlesd_in_if  byte_bus ();
    rlesd_out_if run_bus ();

    rle_scanline_channel_decoder_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_bus),
        .byte_stream (byte_bus),
        .run_stream  (run_bus)
    );

    // decoder model state
    cfg_t       live_cfg;
    int         line_pos;
    phase_t     token_phase;
    bit         half_token;
    logic [6:0] run_left;
    logic [7:0] token_top;
    bit         line_closed;

    out_beat_t  pending_runs [$];
    logic [7:0] seg_bytes [$];
    int         decoded_bytes = 0;
    int         mismatches = 0;
    int         quiet_cycles = 0;
    bit         calm = 1'b0;
    bit         stall_req = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic out_beat_t run_beat(input int start, input logic [6:0] len,
                                           input logic [1:0] ch, input logic [7:0] v);
        out_beat_t beat;
        beat = '0;
        beat.pixel_start = start[12:0];
        beat.run_length = len;
        if (live_cfg.color_mode == CM_DITHER)
        begin
            beat.color.write_mask = MASK_RGB;
            beat.color.red = 8'((int'(v[2:0]) * 255 + 3) / 7);
            beat.color.green = 8'((int'(v[5:3]) * 255 + 3) / 7);
            beat.color.blue = 8'(int'(v[7:6]) * 85);
        end
        else if (live_cfg.channels_used <= GREY_LIMIT && ch == CH_RED)
        begin
            beat.color.write_mask = MASK_RGB;
            beat.color.red = v;
            beat.color.green = v;
            beat.color.blue = v;
        end
        else if (live_cfg.channels_used == GREY_ALPHA)
        begin
            beat.color.write_mask = MASK_ALPHA;
            beat.color.alpha = v;
        end
        else
        begin
            beat.color.write_mask = MASK_RED << ch;
            case (ch)
                CH_RED:   beat.color.red = v;
                CH_GREEN: beat.color.green = v;
                CH_BLUE:  beat.color.blue = v;
                default:  beat.color.alpha = v;
            endcase
        end
        return beat;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic [1:0] ch,
                                        input logic last, output bit has_beat,
                                        output out_beat_t beat);
        int         width;
        bit         complete;
        bit         settle;
        bit         settle_bad;
        logic [6:0] count;
        has_beat = 1'b0;
        beat = '0;
        settle = 1'b0;
        settle_bad = 1'b0;
        complete = 1'b0;
        width = (int'(live_cfg.row_width) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH
                                                            : int'(live_cfg.row_width);
        if (!line_closed)
        begin
            decoded_bytes++;
            if (!half_token)
            begin
                token_top = b;
                if (live_cfg.bytes_per_channel >= 2'd2)
                    half_token = 1'b1;
                else
                    complete = 1'b1;
            end
            else
            begin
                half_token = 1'b0;
                complete = 1'b1;
            end

            if (complete)
            begin
                if (!live_cfg.rle_mode)
                begin
                    if (line_pos >= width)
                    begin
                        settle = 1'b1;
                        settle_bad = 1'b1;
                    end
                    else
                    begin
                        beat = run_beat(line_pos, 7'd1, ch, token_top);
                        line_pos++;
                    end
                    has_beat = 1'b1;
                end
                else if (token_phase == PH_LIT)
                begin
                    beat = run_beat(line_pos, 7'd1, ch, token_top);
                    line_pos++;
                    run_left = run_left - 7'd1;
                    if (run_left == 7'd0)
                        token_phase = PH_CODE;
                    has_beat = 1'b1;
                end
                else if (token_phase == PH_REP)
                begin
                    beat = run_beat(line_pos, run_left, ch, token_top);
                    line_pos += int'(run_left);
                    run_left = 7'd0;
                    token_phase = PH_CODE;
                    has_beat = 1'b1;
                end
                else
                begin
                    count = b[6:0];
                    if (count == 7'd0)
                    begin
                        settle = 1'b1;
                        settle_bad = (line_pos != width);
                        has_beat = 1'b1;
                    end
                    else if (int'(count) > width - line_pos)
                    begin
                        settle = 1'b1;
                        settle_bad = 1'b1;
                        has_beat = 1'b1;
                    end
                    else
                    begin
                        run_left = count;
                        token_phase = b[7] ? PH_LIT : PH_REP;
                    end
                end
            end

            if (last && !settle)
            begin
                settle = 1'b1;
                if (live_cfg.rle_mode)
                    settle_bad = (token_phase != PH_CODE) || (line_pos != width);
                else
                    settle_bad = half_token || (line_pos != width);
                has_beat = 1'b1;
            end

            if (settle)
            begin
                beat.row_done = 1'b1;
                beat.row_status = settle_bad;
                line_closed = 1'b1;
            end
        end
        if (last)
        begin
            line_pos = 0;
            token_phase = PH_CODE;
            half_token = 1'b0;
            run_left = 7'd0;
            token_top = 8'd0;
            line_closed = 1'b0;
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic [1:0] ch, input logic last,
                             input row_kind_t kind, input out_beat_t typed_beat);
        bit        has_beat;
        out_beat_t beat;
        @(negedge clk);
        while (!calm && $urandom_range(99) < 26)
        begin
            byte_bus.valid = 1'b0;
            @(negedge clk);
        end
        byte_bus.valid = 1'b1;
        byte_bus.data_byte = b;
        byte_bus.channel = ch;
        byte_bus.segment_last = last;
        do
            @(posedge clk);
        while (!byte_bus.ready);
        decode_byte(b, ch, last, has_beat, beat);
        if (kind == ROW_PRED && has_beat)
            pending_runs.push_back(beat);
        else if (kind == ROW_TYPED)
            pending_runs.push_back(typed_beat);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [13:0] wdata);
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.wdata = wdata;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            REG_ROW_WIDTH:     live_cfg.row_width = wdata;
            REG_BYTES_PER_CH:  live_cfg.bytes_per_channel = wdata[1:0];
            REG_COLOR_MODE:    live_cfg.color_mode = wdata[1:0];
            REG_CHANNELS_USED: live_cfg.channels_used = wdata[2:0];
            REG_RLE_MODE:      live_cfg.rle_mode = wdata[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic load_setting(input logic [13:0] w, input logic [1:0] bpc,
                                input logic [1:0] cm, input logic [2:0] cu, input logic rle);
        write_reg(REG_ROW_WIDTH, w);
        write_reg(REG_BYTES_PER_CH, {12'($urandom), bpc});
        write_reg(REG_COLOR_MODE, {12'($urandom), cm});
        write_reg(REG_CHANNELS_USED, {11'($urandom), cu});
        write_reg(REG_RLE_MODE, {13'($urandom), rle});
    endtask

    task automatic wait_results();
        @(negedge clk);
        byte_bus.valid = 1'b0;
        while (pending_runs.size() != 0)
            @(posedge clk);
    endtask

    // no beat is pending, but code bytes may still be in flight
    task automatic settle_idle();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void put_code(input logic [7:0] code);
        if (live_cfg.bytes_per_channel >= 2'd2)
            seg_bytes.push_back(8'($urandom));
        seg_bytes.push_back(code);
    endfunction

    function automatic void put_value(input logic [7:0] v);
        seg_bytes.push_back(v);
        if (live_cfg.bytes_per_channel >= 2'd2)
            seg_bytes.push_back(8'($urandom));
    endfunction

    task automatic build_segment(input int width);
        seg_shape_t shape;
        int         pick;
        int         left;
        int         cnt;
        int         keep;
        bit         lit;
        seg_bytes.delete();
        pick = $urandom_range(99);
        if (pick < 70)
            shape = SEG_CLEAN;
        else if (pick < 80)
            shape = SEG_OVER;
        else if (pick < 92)
            shape = SEG_CUT;
        else
            shape = SEG_NOISE;

        if (shape == SEG_NOISE)
        begin
            repeat ($urandom_range(1, 20)) seg_bytes.push_back(8'($urandom));
        end
        else if (live_cfg.rle_mode)
        begin
            left = width;
            while (left > 0)
            begin
                if (shape == SEG_OVER && left < 127 && $urandom_range(2) == 0)
                begin
                    put_code({1'($urandom), 7'($urandom_range(left + 1, 127))});
                    break;
                end
                cnt = (left < 127) ? left : 127;
                cnt = (left > 300) ? $urandom_range(cnt / 2, cnt) : $urandom_range(1, cnt);
                lit = (cnt <= 24) && ($urandom_range(1) == 1);
                put_code({lit, 7'(cnt)});
                if (lit)
                    repeat (cnt) put_value(8'($urandom));
                else
                    put_value(8'($urandom));
                left -= cnt;
            end
            // optional end-of-row code, trailing bytes are dead
            if (left == 0 && $urandom_range(1) == 1)
            begin
                put_code({1'($urandom), 7'd0});
                repeat ($urandom_range(0, 2)) seg_bytes.push_back(8'($urandom));
            end
        end
        else
        begin
            cnt = (width > 64) ? 64 : width;
            if (shape == SEG_OVER)
                cnt += $urandom_range(1, 3);
            repeat (cnt) put_value(8'($urandom));
        end

        if (seg_bytes.size() == 0)
            seg_bytes.push_back(8'($urandom));
        if (shape == SEG_CUT)
        begin
            keep = $urandom_range(1, seg_bytes.size());
            while (seg_bytes.size() > keep)
                void'(seg_bytes.pop_back());
        end
    endtask

    // run beat checker
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && run_bus.valid && run_bus.ready)
        begin
            if (pending_runs.size() == 0)
            begin
                $error("run beat with no expected beat pending");
                mismatches++;
            end
            else
            begin
                want = pending_runs.pop_front();
                check_field("pixel_start", want.pixel_start, run_bus.pixel_start);
                check_field("run_length", want.run_length, run_bus.run_length);
                check_field("write_mask", want.color.write_mask, run_bus.write_mask);
                check_field("red", want.color.red, run_bus.red);
                check_field("green", want.color.green, run_bus.green);
                check_field("blue", want.color.blue, run_bus.blue);
                check_field("alpha", want.color.alpha, run_bus.alpha);
                check_field("row_done", want.row_done, run_bus.row_done);
                check_field("row_status", want.row_status, run_bus.row_status);
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((byte_bus.valid && byte_bus.ready) || (run_bus.valid && run_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // run channel receiver
    initial
    begin
        run_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_req)
            begin
                stall_req = 1'b0;
                run_bus.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            run_bus.ready = rst_n && (calm || $urandom_range(99) >= 26);
        end
    end

    initial
    begin
        int          phase_no;
        int          rows;
        int          pick;
        int          width;
        logic [1:0]  row_ch;
        logic [13:0] width_val;

        rst_n = 1'b0;
        byte_bus.valid = 1'b0;
        byte_bus.data_byte = 8'd0;
        byte_bus.channel = 2'd0;
        byte_bus.segment_last = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_ROW_WIDTH;
        cfg_bus.wdata = 14'd0;

        live_cfg.row_width = 14'd1;
        live_cfg.bytes_per_channel = 2'd1;
        live_cfg.color_mode = 2'd0;
        live_cfg.channels_used = 3'd1;
        live_cfg.rle_mode = 1'b1;
        line_pos = 0;
        token_phase = PH_CODE;
        half_token = 1'b0;
        run_left = 7'd0;
        token_top = 8'd0;
        line_closed = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_SET)
            begin
                settle_idle();
                write_reg(DIRECTED[i].idx, DIRECTED[i].wdata);
            end
            else
                send_byte(DIRECTED[i].data_byte, DIRECTED[i].channel, DIRECTED[i].last,
                          DIRECTED[i].kind, DIRECTED[i].want);
        end

        phase_no = 0;
        while (decoded_bytes < ITEM_TARGET)
        begin
            settle_idle();
            calm = (phase_no == 3) || (phase_no >= 6 && phase_no < 10);
            case (phase_no)
                0: load_setting(14'd1, 2'd0, 2'd3, 3'd0, 1'b1);
                1: load_setting(14'd16383, 2'd3, 2'd1, 3'd7, 1'b1);
                2: load_setting(14'd8192, 2'd1, 2'd2, 3'd4, 1'b0);
                3: load_setting(14'd40, 2'($urandom), 2'($urandom), 3'($urandom), 1'b1);
                default:
                begin
                    pick = $urandom_range(0, 23);
                    if (pick == 0)
                        width_val = 14'd16383;
                    else if (pick == 1)
                        width_val = 14'd8192;
                    else if (pick == 2)
                        width_val = 14'($urandom_range(128, 1000));
                    else if (pick == 3)
                        width_val = 14'd0;
                    else if (pick < 6)
                        width_val = 14'd1;
                    else
                        width_val = 14'($urandom_range(2, 40));
                    load_setting(width_val, 2'($urandom), 2'($urandom), 3'($urandom),
                                 $urandom_range(3) != 0);
                end
            endcase

            // receiver backs off while bytes keep coming
            if (phase_no == 3)
                stall_req = 1'b1;

            width = (int'(live_cfg.row_width) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH
                                                                : int'(live_cfg.row_width);
            rows = (width > 64) ? 1 : $urandom_range(2, 8);
            repeat (rows)
            begin
                build_segment(width);
                row_ch = 2'($urandom);
                foreach (seg_bytes[i])
                    send_byte(seg_bytes[i], row_ch, i == seg_bytes.size() - 1, ROW_PRED,
                              NO_BEAT);
                if ($urandom_range(9) == 0)
                    wait_results();
            end
            phase_no++;
        end

        wait_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_runs.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
